// ===== design/rprib_pkg.sv =====
package rprib_pkg;
   localparam int MAX_ROWS_DEF   = 128;
   localparam int MAX_COLS_DEF   = 4096;
   localparam int INDEX_BITS_DEF = 20;
   localparam int CORDIC_STEPS   = 20;
   localparam int SQRT_STEPS     = 26;

   localparam logic [2:0] OUT_STORED   = 3'd0;
   localparam logic [2:0] OUT_BAD_RING = 3'd1;
   localparam logic [2:0] OUT_DOWNSAMP = 3'd2;
   localparam logic [2:0] OUT_BAD_COL  = 3'd3;
   localparam logic [2:0] OUT_RANGE    = 3'd4;
   localparam logic [2:0] OUT_OCCUPIED = 3'd5;
   localparam logic [2:0] OUT_CLEARED  = 3'd6;

   localparam logic [2:0] REG_ROWS = 3'd0;
   localparam logic [2:0] REG_COLS = 3'd1;
   localparam logic [2:0] REG_DOWN = 3'd2;
   localparam logic [2:0] REG_RMIN = 3'd3;
   localparam logic [2:0] REG_RMAX = 3'd4;

   function automatic logic [23:0] turn_angle(input logic [4:0] i);
      case (i)
         5'd0: turn_angle = 24'd2097152;
         5'd1: turn_angle = 24'd1238021;
         5'd2: turn_angle = 24'd654136;
         5'd3: turn_angle = 24'd332050;
         5'd4: turn_angle = 24'd166669;
         5'd5: turn_angle = 24'd83416;
         5'd6: turn_angle = 24'd41718;
         5'd7: turn_angle = 24'd20860;
         5'd8: turn_angle = 24'd10430;
         5'd9: turn_angle = 24'd5215;
         5'd10: turn_angle = 24'd2608;
         5'd11: turn_angle = 24'd1304;
         5'd12: turn_angle = 24'd652;
         5'd13: turn_angle = 24'd326;
         5'd14: turn_angle = 24'd163;
         5'd15: turn_angle = 24'd81;
         5'd16: turn_angle = 24'd41;
         5'd17: turn_angle = 24'd20;
         5'd18: turn_angle = 24'd10;
         5'd19: turn_angle = 24'd5;
         default: turn_angle = 24'd0;
      endcase
   endfunction

   typedef struct packed {
      logic        start;
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
   } geo_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] angle;
      logic [24:0] range;
   } geo_res_type;
endpackage

// ===== design/rprib_geometry.sv =====
module rprib_geometry
   import rprib_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  geo_cmd_type cmd,
   output geo_res_type res
);
   // One shared step per cycle: squares first, then CORDIC and square root together.
   localparam logic [2:0] S_IDLE = 3'd0, S_SQX = 3'd1, S_SQY = 3'd2, S_SQZ = 3'd3,
                          S_RUN = 3'd4, S_FIN = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic signed [26:0] u_ff, u_in, v_ff, v_in;
   logic [23:0] acc_ff, acc_in;
   logic [48:0] sum_ff, sum_in, rem_ff;
   logic [25:0] root_ff;
   logic signed [23:0] z_ff, z_in, y_ff, y_in;
   logic origin_ff, origin_in;
   logic signed [47:0] sq;
   logic signed [23:0] sq_op;
   logic signed [26:0] su, sv;
   logic [26:0] rounded;

   always_comb begin
      case (state_ff)
         S_SQY: sq_op = y_ff;
         S_SQZ: sq_op = z_ff;
         default: sq_op = 24'(-$signed(u_ff));
      endcase
   end
   assign sq = sq_op * sq_op;
   assign su = u_ff >>> step_ff;
   assign sv = v_ff >>> step_ff;
   logic [4:0] sqrt_shift;
   always_comb begin
      state_in = state_ff; step_in = step_ff; u_in = u_ff; v_in = v_ff; acc_in = acc_ff;
      sum_in = sum_ff; z_in = z_ff; y_in = y_ff; origin_in = origin_ff;
      sqrt_shift = 5'(SQRT_STEPS - 1) - step_ff;
      case (state_ff)
         S_IDLE: if (cmd.start) begin
            u_in = -(27'($signed(cmd.x))); v_in = 27'($signed(cmd.y));
            y_in = cmd.y; z_in = cmd.z; acc_in = '0;
            origin_in = (cmd.x == '0) && (cmd.y == '0);
            state_in = S_SQX;
         end
         S_SQX: begin
            sum_in = 49'($unsigned(sq)); state_in = S_SQY;
            if (u_ff < 0) begin
               u_in = -u_ff; v_in = -v_ff; acc_in = 24'h800000;
            end
         end
         S_SQY: begin sum_in = sum_ff + 49'($unsigned(sq)); state_in = S_SQZ; end
         S_SQZ: begin
            sum_in = sum_ff + 49'($unsigned(sq)); state_in = S_RUN; step_in = '0;
         end
         S_RUN: begin
            if (step_ff < 5'(CORDIC_STEPS)) begin
               if (v_ff >= 0) begin
                  u_in = u_ff + sv; v_in = v_ff - su; acc_in = acc_ff + turn_angle(step_ff);
               end else begin
                  u_in = u_ff - sv; v_in = v_ff + su; acc_in = acc_ff - turn_angle(step_ff);
               end
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(SQRT_STEPS - 1)) state_in = S_FIN;
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
   // Square root works on bit pairs from the top, one pair per RUN cycle.
   logic [48:0] rem_sel;
   logic [25:0] root_sel;
   always_comb begin
      logic [1:0] pair;
      logic [51:0] cur;
      logic [27:0] tst;
      pair = 2'((sum_ff >> {sqrt_shift, 1'b0}) & 49'd3);
      cur = {1'b0, rem_ff, pair};
      tst = {root_ff, 2'b01};
      if (cur >= 52'(tst)) begin
         rem_sel = 49'(cur - 52'(tst)); root_sel = {root_ff[24:0], 1'b1};
      end else begin
         rem_sel = 49'(cur); root_sel = {root_ff[24:0], 1'b0};
      end
   end
   assign rounded = (rem_ff > 49'(root_ff)) ? 27'(root_ff) + 27'd1 : 27'(root_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in; u_ff <= u_in; v_ff <= v_in; acc_ff <= acc_in; sum_ff <= sum_in;
      y_ff <= y_in; z_ff <= z_in; origin_ff <= origin_in;
      if (state_ff == S_SQZ) begin
         rem_ff <= '0; root_ff <= '0;
      end else if (state_ff == S_RUN) begin
         rem_ff <= rem_sel; root_ff <= root_sel;
      end
   end
   logic [24:0] acc_rnd;
   assign acc_rnd = 25'(acc_ff) + 25'd128;
   assign res.done  = (state_ff == S_FIN);
   assign res.angle = origin_ff ? 16'h8000 : acc_rnd[23:8];
   assign res.range = rounded[26:25] != 2'b0 ? 25'h1FFFFFF : rounded[24:0];
endmodule

// ===== design/ring_point_range_image_binner_core.sv =====
// channel | direction | handshake
// csr_    | in        | csr_valid / csr_ready
// req_    | in        | req_valid / req_stall
// rsp_    | out       | rsp_valid / rsp_stall
// A point's result is ready after the geometry step and the checks when a check drops it, or
// after the occupancy read and write as well when it goes on to the pixel lookup.
// With downsampling on, a ring the remainder count has not reached when the geometry step ends
// keeps the block in the check state until the count reaches it. A clear sweeps the occupancy
// memory one word per cycle, 128 words with default sizes. After reset the same sweep runs once
// before the first item is taken. A held result stalls the block until it is taken.
module ring_point_range_image_binner_core
   import rprib_pkg::*;
#(
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int MAX_COLS   = MAX_COLS_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [23:0]           csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic signed [23:0]    req_x_mm,
   input  logic signed [23:0]    req_y_mm,
   input  logic signed [23:0]    req_z_mm,
   input  logic [7:0]            req_ring,
   input  logic [INDEX_BITS-1:0] req_point_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_outcome,
   output logic [6:0]            rsp_row,
   output logic [11:0]           rsp_column,
   output logic [23:0]           rsp_range_mm,
   output logic [23:0]           rsp_max_range_mm
);
   localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int PIXELS = MAX_ROWS * MAX_COLS;
   localparam int PB = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int OCC_W = 1 << CB;
   localparam int OCC_D = (PIXELS + OCC_W - 1) / OCC_W;
   localparam int OB = (OCC_D > 1) ? $clog2(OCC_D) : 1;
   localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_GEO = 3'd2, S_CHK = 3'd3,
                          S_RD = 3'd4, S_WR = 3'd5, S_OUT = 3'd6;
   logic [2:0] state_ff;
   logic [7:0] rows_ff; logic [12:0] cols_ff; logic [6:0] down_ff;
   logic [23:0] rmin_ff, rmax_ff, maxr_ff;
   logic [OB:0] clr_ff;
   logic clr_rsp_ff;
   logic [OCC_W-1:0] occ_mem [OCC_D];
   logic [23:0] prange_mem [PIXELS];
   logic [INDEX_BITS-1:0] pidx_mem [PIXELS];
   logic [OCC_W-1:0] occ_row_ff;
   logic [7:0] ring_ff; logic [INDEX_BITS-1:0] idx_ff;
   logic [2:0] out_ff; logic [6:0] row_ff; logic [11:0] col_ff; logic [23:0] rng_ff;
   logic [12:0] cols_eff, col_c; logic [8:0] rows_eff;
   logic [6:0] mod_ff; logic [7:0] mcnt_ff;
   logic [29:0] prod_ff;
   geo_cmd_type gcmd; geo_res_type gres;
   logic [24:0] rfull_ff;

   assign cols_eff = (cols_ff > 13'(MAX_COLS)) ? 13'(MAX_COLS) : cols_ff;
   assign rows_eff = (rows_ff > 8'(MAX_ROWS)) ? 9'(MAX_ROWS) : 9'(rows_ff);
   assign gcmd.start = (state_ff == S_IDLE) && req_valid && !req_operation;
   assign gcmd.x = req_x_mm; assign gcmd.y = req_y_mm; assign gcmd.z = req_z_mm;
   rprib_geometry u_geo (.clock(clock), .reset(reset), .cmd(gcmd), .res(gres));

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_outcome = out_ff; assign rsp_row = row_ff; assign rsp_column = col_ff;
   assign rsp_range_mm = rng_ff; assign rsp_max_range_mm = maxr_ff;
   assign col_c = 13'((prod_ff + 30'd32768) >> 16);

   logic [31:0] pix;
   assign pix = 32'(ring_ff) * 32'(cols_eff) + 32'(col_ff);
   logic [OB-1:0] ra; logic [CB-1:0] ca;
   assign ra = OB'(pix >> CB);
   assign ca = pix[CB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0; maxr_ff <= '0; clr_rsp_ff <= 1'b0;
         rows_ff <= 8'd64; cols_ff <= 13'd1800; down_ff <= '0;
         rmin_ff <= 24'd1000; rmax_ff <= 24'd100000;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_ROWS: rows_ff <= csr_data[7:0];
               REG_COLS: cols_ff <= csr_data[12:0];
               REG_DOWN: down_ff <= csr_data[6:0];
               REG_RMIN: rmin_ff <= csr_data;
               REG_RMAX: rmax_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_CLR: begin
               occ_mem[clr_ff[OB-1:0]] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (OB+1)'(OCC_D - 1)) begin
                  state_ff <= clr_rsp_ff ? S_OUT : S_IDLE;
               end
            end
            S_IDLE: if (req_valid) begin
               ring_ff <= req_ring; idx_ff <= req_point_index;
               mod_ff <= '0; mcnt_ff <= '0;
               if (req_operation) begin
                  out_ff <= OUT_CLEARED; row_ff <= '0; col_ff <= '0; rng_ff <= '0;
                  clr_ff <= '0; clr_rsp_ff <= 1'b1; state_ff <= S_CLR;
               end else state_ff <= S_GEO;
            end
            S_GEO: begin
               // Ring remainder is counted alongside the geometry unit.
               if (down_ff != '0 && mcnt_ff != ring_ff) begin
                  mcnt_ff <= mcnt_ff + 8'd1;
                  mod_ff <= (mod_ff + 7'd1 == down_ff) ? 7'd0 : mod_ff + 7'd1;
               end
               if (gres.done) begin
                  prod_ff <= 30'(gres.angle) * 30'(cols_eff);
                  rfull_ff <= gres.range;
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (down_ff != '0 && mcnt_ff != ring_ff) begin
                  mcnt_ff <= mcnt_ff + 8'd1;
                  mod_ff <= (mod_ff + 7'd1 == down_ff) ? 7'd0 : mod_ff + 7'd1;
               end else begin
                  rng_ff <= rfull_ff[24] ? 24'hFFFFFF : rfull_ff[23:0];
                  row_ff <= (9'(ring_ff) < rows_eff) ? ring_ff[6:0] : 7'd0;
                  col_ff <= (col_c < cols_eff) ? col_c[11:0] : 12'd0;
                  state_ff <= S_OUT;
                  if (!(9'(ring_ff) < rows_eff)) out_ff <= OUT_BAD_RING;
                  else if (down_ff != '0 && mod_ff != '0) out_ff <= OUT_DOWNSAMP;
                  else if (!(col_c < cols_eff)) out_ff <= OUT_BAD_COL;
                  else if (rfull_ff < 25'(rmin_ff) || rfull_ff > 25'(rmax_ff))
                     out_ff <= OUT_RANGE;
                  else state_ff <= S_RD;
               end
            end
            S_RD: begin
               occ_row_ff <= occ_mem[ra];
               state_ff <= S_WR;
            end
            S_WR: begin
               state_ff <= S_OUT;
               if (pix >= 32'(PIXELS)) out_ff <= OUT_BAD_COL;
               else if (occ_row_ff[ca]) out_ff <= OUT_OCCUPIED;
               else begin
                  occ_row_ff[ca] <= 1'b1;
                  occ_mem[ra] <= occ_row_ff | (OCC_W'(1) << ca);
                  prange_mem[pix[PB-1:0]] <= rng_ff;
                  pidx_mem[pix[PB-1:0]] <= idx_ff;
                  if (rng_ff > maxr_ff) maxr_ff <= rng_ff;
                  out_ff <= OUT_STORED;
               end
            end
            S_OUT: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
